/* hw/rtl/mse_pkg.sv */
// Shared types and constants of the MIPS subset executor.
// Used by mse_exec and mips_subset_instruction_executor; depends on nothing.
package mse_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_EXEC    = 2'd0,
    OP_PRELOAD = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // Primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_J     = 6'b000010;
  localparam logic [5:0] OPC_JAL   = 6'b000011;
  localparam logic [5:0] OPC_BEQ   = 6'b000100;
  localparam logic [5:0] OPC_BNE   = 6'b000101;
  localparam logic [5:0] OPC_ADDIU = 6'b001001;
  localparam logic [5:0] OPC_SLTIU = 6'b001011;
  localparam logic [5:0] OPC_ANDI  = 6'b001100;
  localparam logic [5:0] OPC_ORI   = 6'b001101;
  localparam logic [5:0] OPC_LUI   = 6'b001111;
  localparam logic [5:0] OPC_LB    = 6'b100000;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SB    = 6'b101000;
  localparam logic [5:0] OPC_SW    = 6'b101011;

  // R-type function codes
  localparam logic [5:0] FN_SLL  = 6'b000000;
  localparam logic [5:0] FN_SRL  = 6'b000010;
  localparam logic [5:0] FN_JR   = 6'b001000;
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_SUBU = 6'b100011;
  localparam logic [5:0] FN_AND  = 6'b100100;
  localparam logic [5:0] FN_OR   = 6'b100101;
  localparam logic [5:0] FN_NOR  = 6'b100111;
  localparam logic [5:0] FN_SLTU = 6'b101011;

  localparam logic [31:0] RESET_PC    = 32'h0040_0000;
  localparam logic [31:0] PC_TOP_MASK = 32'hf000_0000;
  localparam logic [4:0]  LINK_REG    = 5'd31;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;

  // Data memory access of one item
  typedef struct packed {
    logic ld_word;
    logic ld_byte;
    logic st_word;  // sw and preload
    logic st_byte;
    logic rd_word;  // read operation
  } mem_ctl_t;

  // Execute stage result
  typedef struct packed {
    logic        dw;
    logic [4:0]  dst;
    logic [31:0] val;
    logic [31:0] next_pc;
    logic [31:0] ea;
    logic [31:0] sdata;
    mem_ctl_t    mem;
  } exe_res_t;

  // Result item, next_pc in the lowest bits
  typedef struct packed {
    logic [31:0] read_word;
    logic        mem_written;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_written;
    logic [31:0] next_pc;
  } out_item_t;

endpackage

/* hw/rtl/mse_exec.sv */
// Decode and execute of one item: ALU, branch/jump target, effective address.
// Depends on mse_pkg.
module mse_exec (
  input  mse_pkg::op_t     op,
  input  logic [31:0]      instr,
  input  logic [31:0]      pc,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  input  logic [31:0]      maddr,
  input  logic [31:0]      mdata,
  output mse_pkg::exe_res_t res
);
  import mse_pkg::*;

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] jtarget;
  logic [31:0] btarget;

  assign opc     = instr[31:26];
  assign fn      = instr[5:0];
  assign rt      = instr[20:16];
  assign rd      = instr[15:11];
  assign sh      = instr[10:6];
  assign imm     = {16'h0000, instr[15:0]};
  assign simm    = {{16{instr[15]}}, instr[15:0]};
  assign pc4     = pc + 32'd4;
  assign jtarget = (pc4 & PC_TOP_MASK) | {4'h0, instr[25:0], 2'b00};
  assign btarget = pc4 + {simm[29:0], 2'b00};

  // Decode the item and compute its effects
  always_comb begin
    res         = '0;
    res.next_pc = pc;
    res.ea      = maddr;
    res.sdata   = mdata;
    unique case (op)
      OP_PRELOAD: res.mem.st_word = 1'b1;
      OP_READ:    res.mem.rd_word = 1'b1;
      OP_NOP:     res.next_pc = pc;
      OP_EXEC: begin
        res.next_pc = pc4;
        res.ea      = a + simm;
        res.sdata   = b;
        if (instr != 32'h0) begin
          unique case (opc)
            OPC_RTYPE: begin
              res.dst = rd;
              res.dw  = 1'b1;
              unique case (fn)
                FN_ADDU: res.val = a + b;
                FN_SUBU: res.val = a - b;
                FN_AND:  res.val = a & b;
                FN_OR:   res.val = a | b;
                FN_NOR:  res.val = ~(a | b);
                FN_SLTU: res.val = {31'h0, a < b};
                FN_SLL:  res.val = b << sh;
                FN_SRL:  res.val = b >> sh;
                FN_JR: begin
                  res.next_pc = a;
                  res.dw      = 1'b0;
                end
                default: res.dw = 1'b0;
              endcase
            end
            OPC_ADDIU: begin res.dst = rt; res.dw = 1'b1; res.val = a + simm; end
            OPC_ANDI:  begin res.dst = rt; res.dw = 1'b1; res.val = a & imm; end
            OPC_ORI:   begin res.dst = rt; res.dw = 1'b1; res.val = a | imm; end
            OPC_SLTIU: begin res.dst = rt; res.dw = 1'b1; res.val = {31'h0, a < simm}; end
            OPC_LUI:   begin res.dst = rt; res.dw = 1'b1; res.val = {instr[15:0], 16'h0000}; end
            OPC_LW:    begin res.dst = rt; res.dw = 1'b1; res.mem.ld_word = 1'b1; end
            OPC_LB:    begin res.dst = rt; res.dw = 1'b1; res.mem.ld_byte = 1'b1; end
            OPC_SW:    res.mem.st_word = 1'b1;
            OPC_SB:    res.mem.st_byte = 1'b1;
            OPC_BEQ:   if (a == b) res.next_pc = btarget;
            OPC_BNE:   if (a != b) res.next_pc = btarget;
            OPC_J:     res.next_pc = jtarget;
            OPC_JAL: begin
              res.dst     = LINK_REG;
              res.dw      = 1'b1;
              res.val     = pc4;
              res.next_pc = jtarget;
            end
            default: res.dw = 1'b0;
          endcase
        end
      end
    endcase
  end

endmodule

/* hw/rtl/mips_subset_instruction_executor.sv */
// Path: stage 1, stage 2, then the output queue of 4 results.
// Throughput: one item per cycle while the queue has room; register file and data
// memory reads are issued a stage ahead, and stage 2 results are forwarded back.
// Reset: PC = 0x400000, registers read zero; the data memory is then cleared one
// word a cycle, all DATA_WORDS words (a power of two), in_tready low meanwhile.
module mips_subset_instruction_executor #(
  parameter int DATA_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: start_pc
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  // Input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // instruction_word, mem_address, mem_data
  input  logic [1:0]   in_tuser,   // operation
  // Result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // next_pc, reg_written, reg_index, reg_value,
                                   // mem_written, read_word, zero pad
);
  import mse_pkg::*;

  localparam int ADDR_W = $clog2(DATA_WORDS);

  // Storage
  logic [31:0] rf_mem [32];
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] rf_vld_r;

  // Reset clearing pass
  logic              clr_r;
  logic [ADDR_W-1:0] clr_idx_r;

  // Architectural PC
  logic [31:0] pc_r;

  // Stage 1: register operands available
  logic        s1_vld_r;
  op_t         s1_op_r;
  logic [31:0] s1_instr_r;
  logic [31:0] s1_maddr_r;
  logic [31:0] s1_mdata_r;
  logic [31:0] rf_a_r;
  logic [31:0] rf_b_r;
  logic        a_vld_r;
  logic        b_vld_r;
  logic        a_byp_vld_r;
  logic        b_byp_vld_r;
  logic [31:0] a_byp_r;
  logic [31:0] b_byp_r;

  // Stage 2: memory word available
  logic              s2_vld_r;
  logic [31:0]       s2_pc_r;
  logic              s2_dw_r;
  logic [4:0]        s2_dst_r;
  logic [31:0]       s2_val_r;
  mem_ctl_t          s2_mem_r;
  logic [1:0]        s2_bsel_r;
  logic [ADDR_W-1:0] s2_idx_r;
  logic [31:0]       s2_sdata_r;
  logic [31:0]       dmem_q_r;
  logic              mfwd_vld_r;
  logic [31:0]       mfwd_r;

  // Output queue
  out_item_t           oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r;
  logic [OQ_PTR_W-1:0] oq_rd_r;
  logic [OQ_PTR_W:0]   oq_cnt_r;

  logic              in_acc;
  logic              oq_pop;
  logic [OQ_PTR_W:0] in_flight;
  logic [4:0]        in_rs;
  logic [4:0]        in_rt;
  logic [4:0]        s1_rs;
  logic [4:0]        s1_rt;
  logic [31:0]       s1_a;
  logic [31:0]       s1_b;
  exe_res_t          ex;
  logic [ADDR_W-1:0] s1_idx;
  logic [31:0]       s2_word;
  logic [7:0]        s2_byte;
  logic [31:0]       s2_wval;
  logic              s2_wr;
  logic              s2_mw;
  logic [31:0]       s2_wdata;
  out_item_t         s2_item;

  // Handshakes and occupancy
  assign cfg_ready  = 1'b1;
  assign in_flight  = {{OQ_PTR_W{1'b0}}, s1_vld_r} + {{OQ_PTR_W{1'b0}}, s2_vld_r} + oq_cnt_r;
  assign in_tready  = !clr_r && (in_flight < (OQ_PTR_W+1)'(OQ_DEPTH));
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (oq_cnt_r != '0);
  assign oq_pop     = out_tvalid && out_tready;
  assign out_tdata  = {1'b0, oq_mem[oq_rd_r]};

  assign in_rs = in_tdata[25:21];
  assign in_rt = in_tdata[20:16];
  assign s1_rs = s1_instr_r[25:21];
  assign s1_rt = s1_instr_r[20:16];

  // Operand select: younger stage first, then write captured at read, then file
  always_comb begin
    priority if (s2_wr && (s2_dst_r == s1_rs)) s1_a = s2_wval;
    else if (a_byp_vld_r)                      s1_a = a_byp_r;
    else if (a_vld_r)                          s1_a = rf_a_r;
    else                                       s1_a = 32'h0;
    priority if (s2_wr && (s2_dst_r == s1_rt)) s1_b = s2_wval;
    else if (b_byp_vld_r)                      s1_b = b_byp_r;
    else if (b_vld_r)                          s1_b = rf_b_r;
    else                                       s1_b = 32'h0;
  end

  mse_exec u_exec (
    .op    (s1_op_r),
    .instr (s1_instr_r),
    .pc    (pc_r),
    .a     (s1_a),
    .b     (s1_b),
    .maddr (s1_maddr_r),
    .mdata (s1_mdata_r),
    .res   (ex)
  );

  assign s1_idx = ex.ea[ADDR_W+1:2];

  // Stage 2: pick memory word, extract byte, merge store byte
  assign s2_word = mfwd_vld_r ? mfwd_r : dmem_q_r;

  always_comb begin
    unique case (s2_bsel_r)
      2'd0: begin
        s2_byte  = s2_word[31:24];
        s2_wdata = {s2_sdata_r[7:0], s2_word[23:0]};
      end
      2'd1: begin
        s2_byte  = s2_word[23:16];
        s2_wdata = {s2_word[31:24], s2_sdata_r[7:0], s2_word[15:0]};
      end
      2'd2: begin
        s2_byte  = s2_word[15:8];
        s2_wdata = {s2_word[31:16], s2_sdata_r[7:0], s2_word[7:0]};
      end
      default: begin
        s2_byte  = s2_word[7:0];
        s2_wdata = {s2_word[31:8], s2_sdata_r[7:0]};
      end
    endcase
    if (s2_mem_r.st_word) s2_wdata = s2_sdata_r;
  end

  always_comb begin
    priority if (s2_mem_r.ld_word) s2_wval = s2_word;
    else if (s2_mem_r.ld_byte)     s2_wval = {{24{s2_byte[7]}}, s2_byte};
    else                           s2_wval = s2_val_r;
  end

  assign s2_wr = s2_vld_r && s2_dw_r;
  assign s2_mw = s2_vld_r && (s2_mem_r.st_word || s2_mem_r.st_byte);

  always_comb begin
    s2_item.next_pc     = s2_pc_r;
    s2_item.reg_written = s2_dw_r;
    s2_item.reg_index   = s2_dw_r ? s2_dst_r : 5'd0;
    s2_item.reg_value   = s2_dw_r ? s2_wval : 32'h0;
    s2_item.mem_written = s2_mem_r.st_word || s2_mem_r.st_byte;
    s2_item.read_word   = s2_mem_r.rd_word ? s2_word : 32'h0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      pc_r      <= RESET_PC;
      rf_vld_r  <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      oq_wr_r   <= '0;
      oq_rd_r   <= '0;
      oq_cnt_r  <= '0;
    end else begin
      // Advance the clearing pass
      if (clr_r) begin
        if (clr_idx_r == ADDR_W'(DATA_WORDS - 1)) clr_r <= 1'b0;
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      // Advance the PC with the executing item; a configuration write overrides
      if (cfg_valid && cfg_ready) pc_r <= cfg_data;
      else if (s1_vld_r)          pc_r <= ex.next_pc;
      if (s2_wr) rf_vld_r[s2_dst_r] <= 1'b1;
      s1_vld_r <= in_acc;
      s2_vld_r <= s1_vld_r;
      // Queue push from stage 2, pop on output transfer
      if (s2_vld_r) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop)   oq_rd_r <= oq_rd_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + {{OQ_PTR_W{1'b0}}, s2_vld_r} - {{OQ_PTR_W{1'b0}}, oq_pop};
    end
  end

  // Stage 1 payload and register file read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= op_t'(in_tuser);
      s1_instr_r  <= in_tdata[31:0];
      s1_maddr_r  <= in_tdata[63:32];
      s1_mdata_r  <= in_tdata[95:64];
      rf_a_r      <= rf_mem[in_rs];
      rf_b_r      <= rf_mem[in_rt];
      a_vld_r     <= rf_vld_r[in_rs];
      b_vld_r     <= rf_vld_r[in_rt];
      a_byp_vld_r <= s2_wr && (s2_dst_r == in_rs);
      b_byp_vld_r <= s2_wr && (s2_dst_r == in_rt);
      a_byp_r     <= s2_wval;
      b_byp_r     <= s2_wval;
    end
  end

  // Register file write back
  always_ff @(posedge clk) begin
    if (s2_wr) rf_mem[s2_dst_r] <= s2_wval;
  end

  // Stage 2 payload, data memory read and same-word forward
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_pc_r    <= ex.next_pc;
      s2_dw_r    <= ex.dw && (ex.dst != 5'd0);
      s2_dst_r   <= ex.dst;
      s2_val_r   <= ex.val;
      s2_mem_r   <= ex.mem;
      s2_bsel_r  <= ex.ea[1:0];
      s2_idx_r   <= s1_idx;
      s2_sdata_r <= ex.sdata;
      dmem_q_r   <= dmem[s1_idx];
      mfwd_vld_r <= s2_mw && (s2_idx_r == s1_idx);
      mfwd_r     <= s2_wdata;
    end
  end

  // Data memory write: clearing pass, then stores and preloads
  always_ff @(posedge clk) begin
    if (clr_r) begin
      dmem[clr_idx_r] <= 32'h0;
    end else if (s2_mw) begin
      dmem[s2_idx_r] <= s2_wdata;
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (s2_vld_r) oq_mem[oq_wr_r] <= s2_item;
  end

  // Queue never overflows
  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (oq_cnt_r < (OQ_PTR_W+1)'(OQ_DEPTH)) || oq_pop)
    else $error("result queue overflow");

  // Items in flight stay within queue capacity
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight <= (OQ_PTR_W+1)'(OQ_DEPTH))
    else $error("too many items in flight");

  // R0 is never written
  a_r0_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0])
    else $error("R0 marked written");

  // A store followed by a read of the same word is forwarded
  a_mem_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_mw && (s2_idx_r == s1_idx)) |=> mfwd_vld_r)
    else $error("memory forward missed");

  // No item enters during the clearing pass
  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    $past(clr_r) && clr_r |-> !s1_vld_r)
    else $error("item accepted while clearing");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench of mips_subset_instruction_executor: a scoreboard class predicts
// each retired item. Plain tasks drive the input and configuration streams.
// Depends on mse_pkg and the executor RTL only.
`timescale 1ns / 100ps

module tb_top;
  import mse_pkg::*;

  localparam int MEM_WORDS       = 1024;
  localparam int MEM_AW          = $clog2(MEM_WORDS);
  localparam int ITEMS_PER_PHASE = 115;
  localparam int STALL_LIMIT     = 5000;  // covers the memory clearing pass after reset
  localparam int TAIL_CYCLES     = 8;     // wait after draining, with margin for stray results
  localparam int MAX_PRINTED     = 40;
  localparam logic [5:0] FN_UNUSED = 6'b111111;

  // Predicts the architectural effect of every accepted item and checks retired results
  class retire_scoreboard;
    logic [31:0] pc;
    logic [31:0] regs [32];
    logic [31:0] mem [MEM_WORDS];
    out_item_t   retire_queue [$];
    int          mismatches;

    function new();
      pc = RESET_PC;
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      mismatches = 0;
    endfunction

    function logic [MEM_AW-1:0] slot(logic [31:0] addr);
      return addr[MEM_AW+1:2];
    endfunction

    function int pending();
      return retire_queue.size();
    endfunction

    function void load_pc(logic [31:0] value);
      pc = value;
    endfunction

    // Apply one item to the model state and queue the result it retires
    function void execute_item(op_t op, logic [31:0] iw, logic [31:0] addr,
                               logic [31:0] data);
      logic [5:0]  opc, fn;
      logic [4:0]  rs, rt, rd, sh, dst;
      logic [31:0] imm, simm, a, b, ea, val, w;
      logic [7:0]  by;
      int unsigned sft;
      logic        dw;
      out_item_t   e;
      e = '0;
      dw = 1'b0;
      dst = '0;
      val = '0;
      opc = iw[31:26];
      rs = iw[25:21];
      rt = iw[20:16];
      rd = iw[15:11];
      sh = iw[10:6];
      fn = iw[5:0];
      imm = {16'h0, iw[15:0]};
      simm = {{16{iw[15]}}, iw[15:0]};
      a = regs[rs];
      b = regs[rt];
      ea = a + simm;
      // byte 0 of a word sits in bits 31..24
      sft = (3 - ea[1:0]) * 8;
      case (op)
        OP_PRELOAD: begin
          mem[slot(addr)] = data;
          e.mem_written = 1'b1;
        end
        OP_READ: e.read_word = mem[slot(addr)];
        OP_EXEC: begin
          pc = pc + 32'd4;
          if (iw != '0) begin
            case (opc)
              OPC_RTYPE: begin
                dst = rd;
                dw = 1'b1;
                case (fn)
                  FN_ADDU: val = a + b;
                  FN_SUBU: val = a - b;
                  FN_AND:  val = a & b;
                  FN_OR:   val = a | b;
                  FN_NOR:  val = ~(a | b);
                  FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                  FN_SLL:  val = b << sh;
                  FN_SRL:  val = b >> sh;
                  FN_JR: begin
                    pc = a;
                    dw = 1'b0;
                  end
                  default: dw = 1'b0;
                endcase
              end
              OPC_ADDIU: begin dst = rt; dw = 1'b1; val = a + simm; end
              OPC_ANDI:  begin dst = rt; dw = 1'b1; val = a & imm; end
              OPC_ORI:   begin dst = rt; dw = 1'b1; val = a | imm; end
              OPC_SLTIU: begin dst = rt; dw = 1'b1; val = (a < simm) ? 32'd1 : 32'd0; end
              OPC_LUI:   begin dst = rt; dw = 1'b1; val = imm << 16; end
              OPC_LW:    begin dst = rt; dw = 1'b1; val = mem[slot(ea)]; end
              OPC_LB: begin
                w = mem[slot(ea)];
                by = 8'(w >> sft);
                dst = rt;
                dw = 1'b1;
                val = {{24{by[7]}}, by};
              end
              OPC_SW: begin
                mem[slot(ea)] = b;
                e.mem_written = 1'b1;
              end
              OPC_SB: begin
                mem[slot(ea)] = (mem[slot(ea)] & ~(32'hff << sft)) | ({24'h0, b[7:0]} << sft);
                e.mem_written = 1'b1;
              end
              OPC_BEQ: if (a == b) pc = pc + (simm << 2);
              OPC_BNE: if (a != b) pc = pc + (simm << 2);
              OPC_J: pc = (pc & PC_TOP_MASK) | {4'h0, iw[25:0], 2'b00};
              OPC_JAL: begin
                dst = LINK_REG;
                dw = 1'b1;
                val = pc;
                pc = (pc & PC_TOP_MASK) | {4'h0, iw[25:0], 2'b00};
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      e.next_pc = pc;
      // R0 stays zero, so a write to it never shows
      if (dw && dst != '0) begin
        regs[dst] = val;
        e.reg_written = 1'b1;
        e.reg_index = dst;
        e.reg_value = val;
      end
      retire_queue.insert(retire_queue.size(), e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Compare one retired result with the oldest prediction
    task check_retire(logic [103:0] raw);
      out_item_t got, want;
      got = raw[102:0];
      if (retire_queue.size() == 0) begin
        report_mismatch("result with nothing pending, next_pc", got.next_pc, '0);
      end else begin
        want = retire_queue.pop_front();
        if (got.next_pc !== want.next_pc)
          report_mismatch("next_pc", got.next_pc, want.next_pc);
        if (got.reg_written !== want.reg_written)
          report_mismatch("reg_written", 32'(got.reg_written), 32'(want.reg_written));
        if (got.reg_index !== want.reg_index)
          report_mismatch("reg_index", 32'(got.reg_index), 32'(want.reg_index));
        if (got.reg_value !== want.reg_value)
          report_mismatch("reg_value", got.reg_value, want.reg_value);
        if (got.mem_written !== want.mem_written)
          report_mismatch("mem_written", 32'(got.mem_written), 32'(want.mem_written));
        if (got.read_word !== want.read_word)
          report_mismatch("read_word", got.read_word, want.read_word);
      end
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // instruction_word, mem_address, mem_data
  logic [1:0]   in_tuser;   // operation
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // next_pc, reg_written, reg_index, reg_value,
                            // mem_written, read_word, zero pad

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          quiet_cycles = 0;
  retire_scoreboard sb = new();

  mips_subset_instruction_executor #(
    .DATA_WORDS(MEM_WORDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Randomly stall the result stream
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_retire(out_tdata);
  end

  // Abort when no transfer happens on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** mips_subset_instruction_executor: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs,
                              logic [4:0] rt, logic [4:0] sh);
    return {OPC_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rt, logic [4:0] rs,
                              logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function logic [31:0] enc_j(logic [5:0] opc, logic [25:0] target);
    return {opc, target};
  endfunction

  // Favor a few low registers so results feed the next instructions
  function logic [4:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 5'($urandom_range(4));
    if (r < 60) return LINK_REG;
    return 5'($urandom_range(31));
  endfunction

  function logic [15:0] pick_imm();
    return $urandom_range(1) ? 16'($urandom_range(63)) : 16'($urandom);
  endfunction

  function logic [31:0] pick_addr();
    return $urandom_range(1) ? 32'($urandom_range(255)) : 32'($urandom);
  endfunction

  // Mostly well-formed instructions with random fields, the rest noise
  function logic [31:0] gen_word();
    int r, k;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    r = $urandom_range(99);
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    sh = 5'($urandom_range(31));
    imm = pick_imm();
    if (r < 4) return '0;
    if (r < 10) return 32'($urandom);
    if (r < 13) return enc_r(6'($urandom_range(63)), rd, rs, rt, sh);
    k = $urandom_range(21);
    // base half of the memory accesses on R0 so loads see earlier stores
    if (k >= 14 && k <= 17 && $urandom_range(1)) rs = 5'd0;
    case (k)
      0:  return enc_r(FN_ADDU, rd, rs, rt, sh);
      1:  return enc_r(FN_SUBU, rd, rs, rt, sh);
      2:  return enc_r(FN_AND, rd, rs, rt, sh);
      3:  return enc_r(FN_OR, rd, rs, rt, sh);
      4:  return enc_r(FN_NOR, rd, rs, rt, sh);
      5:  return enc_r(FN_SLTU, rd, rs, rt, sh);
      6:  return enc_r(FN_SLL, rd, rs, rt, sh);
      7:  return enc_r(FN_SRL, rd, rs, rt, sh);
      8:  return enc_r(FN_JR, rd, rs, rt, sh);
      9:  return enc_i(OPC_ADDIU, rt, rs, imm);
      10: return enc_i(OPC_ANDI, rt, rs, imm);
      11: return enc_i(OPC_ORI, rt, rs, imm);
      12: return enc_i(OPC_SLTIU, rt, rs, imm);
      13: return enc_i(OPC_LUI, rt, rs, imm);
      14: return enc_i(OPC_LW, rt, rs, imm);
      15: return enc_i(OPC_LB, rt, rs, imm);
      16: return enc_i(OPC_SW, rt, rs, imm);
      17: return enc_i(OPC_SB, rt, rs, imm);
      18: return enc_i(OPC_BEQ, rt, rs, imm);
      19: return enc_i(OPC_BNE, rt, rs, imm);
      20: return enc_j(OPC_J, 26'($urandom));
      default: return enc_j(OPC_JAL, 26'($urandom));
    endcase
  endfunction

  // Present one item, idling first as the current mode asks, and hold it until transfer
  task send_item(op_t op, logic [31:0] iw, logic [31:0] addr, logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {data, addr, iw};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    sb.execute_item(op, iw, addr, data);
  endtask

  task exec_word(logic [31:0] iw);
    send_item(OP_EXEC, iw, $urandom, $urandom);
  endtask

  // Hold the input off until every predicted result has retired
  task drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_start_pc(logic [31:0] value);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.load_pc(value);
    cfg_valid <= 1'b0;
  endtask

  task random_item();
    int r;
    r = $urandom_range(99);
    if (r < 8) send_item(OP_PRELOAD, $urandom, pick_addr(), $urandom);
    else if (r < 14) send_item(OP_READ, $urandom, pick_addr(), $urandom);
    else if (r < 17) send_item(OP_NOP, $urandom, $urandom, $urandom);
    else exec_word(gen_word());
  endtask

  initial begin
    logic [31:0] pc_plan [8];
    pc_plan = '{32'hffff_fffc, 32'h0000_0000, 32'hffff_ffff, RESET_PC,
                32'($urandom), 32'h0000_0001, 32'($urandom), 32'h8000_0000};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_NOP;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every instruction and the corner cases
    send_item(OP_PRELOAD, $urandom, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_READ, $urandom, 32'hffff_fffc, 32'h0);
    exec_word(enc_i(OPC_LUI, 5'd1, 5'd0, 16'hffff));
    exec_word(enc_i(OPC_ORI, 5'd1, 5'd1, 16'hffff));
    exec_word(enc_i(OPC_ADDIU, 5'd2, 5'd0, 16'h8000));
    exec_word(enc_r(FN_ADDU, 5'd3, 5'd1, 5'd2, 5'd0));
    exec_word(enc_r(FN_SUBU, 5'd4, 5'd0, 5'd1, 5'd0));
    exec_word(enc_r(FN_AND, 5'd5, 5'd1, 5'd2, 5'd0));
    exec_word(enc_r(FN_OR, 5'd6, 5'd4, 5'd2, 5'd0));
    exec_word(enc_r(FN_NOR, 5'd7, 5'd0, 5'd0, 5'd0));
    exec_word(enc_r(FN_SLTU, 5'd8, 5'd0, 5'd1, 5'd0));
    exec_word(enc_r(FN_SLL, 5'd9, 5'd0, 5'd1, 5'd31));
    exec_word(enc_r(FN_SRL, 5'd10, 5'd0, 5'd1, 5'd31));
    exec_word(enc_i(OPC_ANDI, 5'd11, 5'd1, 16'h8000));
    exec_word(enc_i(OPC_SLTIU, 5'd12, 5'd0, 16'hffff));
    // word at the top of memory, then a single byte at the far end of word 0
    exec_word(enc_i(OPC_SW, 5'd9, 5'd0, 16'hfffc));
    exec_word(enc_i(OPC_SB, 5'd1, 5'd0, 16'h0003));
    exec_word(enc_i(OPC_LW, 5'd13, 5'd0, 16'hfffd));
    exec_word(enc_i(OPC_LB, 5'd14, 5'd0, 16'h0003));
    exec_word(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hffff));
    exec_word(enc_i(OPC_BNE, 5'd0, 5'd1, 16'h7fff));
    exec_word(enc_j(OPC_JAL, 26'h3ff_ffff));
    // jump register to an unaligned target
    exec_word(enc_r(FN_JR, 5'd0, 5'd1, 5'd0, 5'd0));
    exec_word(enc_j(OPC_J, 26'h0));
    exec_word(32'h0000_0000);
    exec_word(32'hffff_ffff);
    exec_word(enc_r(FN_UNUSED, 5'd16, 5'd1, 5'd1, 5'd0));
    // a write aimed at R0 is dropped
    exec_word(enc_i(OPC_ADDIU, 5'd0, 5'd1, 16'h1234));
    send_item(OP_NOP, $urandom, $urandom, $urandom);

    // Random phases, each with its own start PC and idling mode
    for (int p = 0; p < 8; p++) begin
      write_start_pc(pc_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2 || $urandom_range(99) == 0) drain_results();
        random_item();
      end
    end

    // Let everything retire, then allow stray results to show up
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** mips_subset_instruction_executor: PASSED **");
    end else begin
      $display("** mips_subset_instruction_executor: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mse_pkg.sv
hw/rtl/mse_exec.sv
hw/rtl/mips_subset_instruction_executor.sv
verif/tb_top.sv
